// ----- src/ldm_pkg.sv -----
// Shared types, constants and the divide-by-255 helper for the LED pixel to DMX mapper.
`default_nettype none

package ldm_pkg;

  // Universe size in slots; a pixel whose start address passes the limit moves on.
  localparam int unsigned SLOTS_PER_UNIVERSE = 512;
  localparam logic [9:0]  ADDR_LIMIT         = 10'(SLOTS_PER_UNIVERSE - 2);

  // Three channels per pixel: red, green, blue.
  localparam int unsigned NUM_COLORS = 3;
  localparam logic [15:0] ROUND_BIAS = 16'd127;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STRIP_BRIGHT = 2'd0,
    REG_START_UNIV   = 2'd1,
    REG_START_ADDR   = 2'd2
  } cfg_reg_t;

  // Placement of one pixel: universe buffer index and slot of its red channel.
  typedef struct packed {
    logic [7:0] univ_idx;
    logic [8:0] slot_base;
  } place_t;

  // Exact floor(x / 255) for x up to 255 * 255 + 254, without a divider.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    y = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return y[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- src/led_pixel_to_dmx_mapper.sv -----
// Top level of the LED pixel to DMX channel mapper.
//
//   Channel | Direction | Handshake          | Contents
//   in_     | request   | in_tvalid/tready   | one RGB pixel, brightness, frame start
//   out_    | result    | out_tvalid/tready  | one DMX channel write, three per pixel
//   cfg_    | config    | cfg_valid/ready    | register index and write data
//
// Each pixel passes three compute stages (brightness product, effective
// brightness, lane products) and the hand-off into the output buffer; these
// overlap with the three writes of the previous pixel.
// The next pixel is taken once the previous one has reached the output buffer.
// Reset is synchronous; it clears the counters, the stage valids and the buffer.
// A stalled result side holds the last compute stage until the buffer drains.
`default_nettype none

module led_pixel_to_dmx_mapper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Pixel requests.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // red[7:0], green[15:8], blue[23:16], led_brightness[31:24]
  input  wire logic        in_tuser,   // frame_start
  // Channel writes.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // univ_idx[7:0], slot_index[16:8],
                                       // channel_value[24:17], zero[31:25]
  output logic             out_tlast,  // last_of_pixel
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  logic [7:0]      strip_r;
  logic [7:0]      start_univ_r;
  logic [9:0]      start_addr_r;
  logic            accept;
  logic            v1_r;
  logic            v2_r;
  logic            v3_r;
  logic            buf_free;
  logic            buf_load;
  logic [15:0]     bprod_r;
  logic [7:0]      eff_r;
  logic [7:0]      red_r;
  logic [7:0]      green_r;
  logic [7:0]      blue_r;
  logic [7:0]      val_red;
  logic [7:0]      val_green;
  logic [7:0]      val_blue;
  ldm_pkg::place_t place;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = !(v1_r || v2_r || v3_r);
  assign buf_load  = v3_r && buf_free;

  // Configuration registers; an unused index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r      <= 8'd255;
      start_univ_r <= 8'd1;
      start_addr_r <= 10'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ldm_pkg::REG_STRIP_BRIGHT: strip_r      <= cfg_data[7:0];
        ldm_pkg::REG_START_UNIV:   start_univ_r <= cfg_data[7:0];
        ldm_pkg::REG_START_ADDR:   start_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valids; one pixel in the compute stages at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r || (v3_r && !buf_free);
    end
  end

  // Stage one: capture colors and the raw brightness product.
  always_ff @(posedge clk) begin
    if (accept) begin
      red_r   <= in_tdata[7:0];
      green_r <= in_tdata[15:8];
      blue_r  <= in_tdata[23:16];
      bprod_r <= 16'(in_tdata[31:24]) * 16'(strip_r);
    end
  end

  // Stage two: effective brightness.
  always_ff @(posedge clk) begin
    if (v1_r) begin
      eff_r <= ldm_pkg::div255(bprod_r);
    end
  end

  ldm_place u_place (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_tuser),
    .start_univ  (start_univ_r),
    .start_addr  (start_addr_r),
    .place_r     (place)
  );

  // Stage three: one lane per color.
  ldm_lane u_lane_red (
    .clk   (clk),
    .load  (v2_r),
    .color (red_r),
    .eff   (eff_r),
    .value (val_red)
  );

  ldm_lane u_lane_green (
    .clk   (clk),
    .load  (v2_r),
    .color (green_r),
    .eff   (eff_r),
    .value (val_green)
  );

  ldm_lane u_lane_blue (
    .clk   (clk),
    .load  (v2_r),
    .color (blue_r),
    .eff   (eff_r),
    .value (val_blue)
  );

  ldm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (buf_load),
    .val_red    (val_red),
    .val_green  (val_green),
    .val_blue   (val_blue),
    .place      (place),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- src/ldm_place.sv -----
// Address generator: running universe and DMX address, reloaded on frame start.
`default_nettype none

module ldm_place (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            frame_start,
  input  wire logic [7:0]      start_univ,
  input  wire logic [9:0]      start_addr,
  output ldm_pkg::place_t      place_r
);

  logic [7:0] univ_r;
  logic [9:0] addr_r;
  logic [7:0] univ_sel;
  logic [9:0] addr_sel;
  logic [7:0] univ_nxt;
  logic [9:0] addr_nxt;
  logic [9:0] addr_use;

  // Pick the counters, fix address zero, and roll over a full universe.
  always_comb begin
    univ_sel = frame_start ? start_univ : univ_r;
    addr_sel = frame_start ? start_addr : addr_r;
    if (addr_sel == 10'd0) begin
      addr_sel = 10'd1;
    end
    univ_nxt = univ_sel;
    addr_use = addr_sel;
    if (addr_sel > ldm_pkg::ADDR_LIMIT) begin
      univ_nxt = univ_sel + 8'd1;
      addr_use = 10'd1;
    end
    addr_nxt = addr_use + 10'd3;
  end

  // Counters advance once per accepted pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      univ_r <= 8'd1;
      addr_r <= 10'd1;
    end else if (accept) begin
      univ_r <= univ_nxt;
      addr_r <= addr_nxt;
    end
  end

  // Placement of the pixel just taken, held until the output buffer loads it.
  always_ff @(posedge clk) begin
    if (accept) begin
      place_r.univ_idx  <= univ_nxt - 8'd1;
      place_r.slot_base <= 9'(addr_use - 10'd1);
    end
  end

endmodule

`default_nettype wire

// ----- src/ldm_lane.sv -----
// One color lane: scales a color component by the effective brightness with rounding.
`default_nettype none

module ldm_lane (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic [7:0] color,
  input  wire logic [7:0] eff,
  output logic      [7:0] value
);

  logic [15:0] prod_r;

  // Product plus rounding bias; the largest sum still fits in 16 bits.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= (16'(color) * 16'(eff)) + ldm_pkg::ROUND_BIAS;
    end
  end

  assign value = ldm_pkg::div255(prod_r);

endmodule

`default_nettype wire

// ----- src/ldm_merge.sv -----
// Output buffer: takes the three lane results of a pixel and sends them as three writes.
`default_nettype none

module ldm_merge (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic [7:0]      val_red,
  input  wire logic [7:0]      val_green,
  input  wire logic [7:0]      val_blue,
  input  wire ldm_pkg::place_t place,
  output logic                 free,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [31:0]          out_tdata,
  output logic                 out_tlast
);

  logic            busy_r;
  logic [1:0]      phase_r;
  logic [7:0]      red_r;
  logic [7:0]      green_r;
  logic [7:0]      blue_r;
  ldm_pkg::place_t place_q_r;
  logic [7:0]      cur_val;
  logic            take;
  logic            done;

  assign take = busy_r && out_tready;
  assign done = take && (phase_r == 2'd2);
  assign free = !busy_r || done;

  // Phase tracks which of the three channels is on the bus.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 2'd0;
    end else if (load) begin
      busy_r  <= 1'b1;
      phase_r <= 2'd0;
    end else if (done) begin
      busy_r  <= 1'b0;
      phase_r <= 2'd0;
    end else if (take) begin
      phase_r <= phase_r + 2'd1;
    end
  end

  // Result payload, captured from the lanes when the buffer frees up.
  always_ff @(posedge clk) begin
    if (load) begin
      red_r     <= val_red;
      green_r   <= val_green;
      blue_r    <= val_blue;
      place_q_r <= place;
    end
  end

  // Select the channel value for the current phase.
  always_comb begin
    unique case (phase_r)
      2'd0:    cur_val = red_r;
      2'd1:    cur_val = green_r;
      default: cur_val = blue_r;
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = (phase_r == 2'd2);
  assign out_tdata  = {7'd0, cur_val, place_q_r.slot_base + {7'd0, phase_r},
                       place_q_r.univ_idx};

endmodule

`default_nettype wire

// ----- src/ldm_checker.sv -----
// Port-level checker for the LED pixel to DMX mapper, bound to the top level.
`default_nettype none

module ldm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  // A stalled write stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("channel write withdrawn while stalled");

  // The writes of one pixel follow each other without a gap.
  a_pixel_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside the writes of one pixel");

  // Writes of one pixel share a universe and use consecutive slots.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      (out_tdata[7:0] == $past(out_tdata[7:0])) &&
      (out_tdata[16:8] == $past(out_tdata[16:8]) + 9'd1))
    else $error("pixel writes not on consecutive slots of one universe");

  // After a pixel is taken the block is busy computing it.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("pixel taken while the previous one is in the compute stages");

endmodule

bind led_pixel_to_dmx_mapper ldm_checker u_ldm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
